### sv/fnvb_pkg.sv
// ============================================================================
// FNV-1a bucket hasher package
// Constants, widths and shared types of the FNV-1a 64-bit bucket hasher.
// ============================================================================
package fnvb_pkg;

    localparam int HASH_W   = 64;
    localparam int BYTE_W   = 8;
    localparam int BUCKET_W = 32;

    localparam int ID_BYTES_DEFAULT = 16;

    localparam logic [HASH_W-1:0]   FNV_BASIS     = 64'hCBF2_9CE4_8422_2325;
    // The 64-bit prime is 2^40 + 0x1B3, so the product splits into a shift
    // and a narrow constant multiply.
    localparam logic [HASH_W-1:0]   FNV_PRIME_LOW = 64'h0000_0000_0000_01B3;
    localparam int                  FNV_PRIME_SHIFT = 40;

    localparam logic [BUCKET_W-1:0] BUCKET_RESET  = 32'd16;

    // One quotient bit per step of the shared remainder unit.
    localparam int DIV_STEPS = HASH_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef struct packed {
        logic busy;
        logic done;
    } fnvb_div_stat_t;

endpackage

### sv/fnvb_mix.sv
// ============================================================================
// FNV-1a byte mix
// Folds one byte into the running hash: XOR, then multiply by the prime.
// ============================================================================
module fnvb_mix
    import fnvb_pkg::*;
(
    input  logic [HASH_W-1:0] hash,
    input  logic [BYTE_W-1:0] id_byte,
    output logic [HASH_W-1:0] hash_mixed
);

    logic [HASH_W-1:0] hash_x;

    assign hash_x     = hash ^ {{(HASH_W-BYTE_W){1'b0}}, id_byte};
    assign hash_mixed = (hash_x * FNV_PRIME_LOW) + (hash_x << FNV_PRIME_SHIFT);

endmodule

### sv/fnvb_mod_unit.sv
// ============================================================================
// FNV-1a remainder unit
// Restoring remainder of a 64-bit hash by a 32-bit divisor, one bit a cycle.
// ============================================================================
module fnvb_mod_unit
    import fnvb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [HASH_W-1:0]   dividend,
    input  logic [BUCKET_W-1:0] divisor,
    output fnvb_div_stat_t      stat,
    output logic [BUCKET_W-1:0] remainder
);

    logic [HASH_W-1:0]    shift_reg;
    logic [HASH_W-1:0]    shift_next;
    logic [BUCKET_W-1:0]  rem_reg;
    logic [BUCKET_W-1:0]  rem_next;
    logic [BUCKET_W-1:0]  divisor_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [BUCKET_W:0]    rem_shift;
    logic [BUCKET_W:0]    rem_diff;

    // The partial remainder stays below the divisor, so after the shift it
    // fits one extra bit and the difference fits the register again.
    assign rem_shift = {rem_reg, shift_reg[HASH_W-1]};
    assign rem_diff  = rem_shift - {1'b0, divisor_reg};

    always_comb
    begin
        shift_next = shift_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            shift_next = dividend;
            rem_next   = '0;
            cnt_next   = '0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            shift_next = {shift_reg[HASH_W-2:0], 1'b0};
            if (rem_diff[BUCKET_W])
            begin
                rem_next = rem_shift[BUCKET_W-1:0];
            end
            else
            begin
                rem_next = rem_diff[BUCKET_W-1:0];
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        if (start)
        begin
            divisor_reg <= divisor;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign remainder = rem_reg;

endmodule

### sv/fnv1a64_uuid_bucket_unit.sv
// ============================================================================
// FNV-1a 64-bit identifier bucket unit
// Hashes fixed-length identifiers byte by byte and reduces each hash to a
// bucket index modulo a configurable bucket count.
// ============================================================================
// Usage:
// The input channel (id_valid, id_stall, id_byte) carries one identifier
// byte per transaction, first byte first. Each byte is absorbed in the
// cycle it is accepted. After byte number ID_BYTES the unit computes the
// remainder with a shared compare-and-subtract unit, one bit of the 64-bit
// hash per cycle, and holds id_stall high meanwhile. The result transaction
// (res_valid, res_stall, bucket_index, full_hash) is loaded into the output
// register once the remainder unit flags done and that register is free.
// A stalled result holds in the output register and bytes of the next
// identifier are still taken; once the next reduction is done, id_stall
// stays high until the output register is free.
// The bucket count is written through cfg_valid/cfg_ready/bucket_count,
// which is always ready; a count of zero gives bucket index zero.
// Reset restores the offset basis, clears the byte position and res_valid,
// and sets the bucket count to 16.
// ============================================================================
module fnv1a64_uuid_bucket_unit
    import fnvb_pkg::*;
#(
    parameter int ID_BYTES = ID_BYTES_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                id_valid,
    output logic                id_stall,
    input  logic [BYTE_W-1:0]   id_byte,
    output logic                res_valid,
    input  logic                res_stall,
    output logic [BUCKET_W-1:0] bucket_index,
    output logic [HASH_W-1:0]   full_hash,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [BUCKET_W-1:0] bucket_count
);

    localparam int POS_W = (ID_BYTES > 1) ? $clog2(ID_BYTES) : 1;

    typedef enum logic [2:0] {
        ST_ABSORB = 3'b001,
        ST_DIVIDE = 3'b010,
        ST_HOLD   = 3'b100
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [HASH_W-1:0]   hash_reg;
    logic [HASH_W-1:0]   hash_final_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [BUCKET_W-1:0] bucket_count_reg;
    logic                zero_div_reg;
    logic                res_valid_reg;
    logic [BUCKET_W-1:0] bucket_index_reg;
    logic [HASH_W-1:0]   full_hash_reg;

    logic [HASH_W-1:0]   hash_mixed;
    logic                byte_accept;
    logic                last_byte;
    logic                out_free;
    logic                load_out;
    fnvb_div_stat_t      div_stat;
    logic [BUCKET_W-1:0] div_rem;

    fnvb_mix u_mix (
        .hash       (hash_reg),
        .id_byte    (id_byte),
        .hash_mixed (hash_mixed)
    );

    fnvb_mod_unit u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (byte_accept && last_byte),
        .dividend  (hash_mixed),
        .divisor   (bucket_count_reg),
        .stat      (div_stat),
        .remainder (div_rem)
    );

    assign id_stall    = (state_reg != ST_ABSORB);
    assign byte_accept = id_valid && !id_stall;
    assign last_byte   = (pos_reg == POS_W'(ID_BYTES - 1));
    assign out_free    = !res_valid_reg || !res_stall;
    assign load_out    = out_free
                         && ((state_reg == ST_DIVIDE && div_stat.done)
                             || state_reg == ST_HOLD);
    assign cfg_ready   = 1'b1;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_ABSORB:
            begin
                if (byte_accept && last_byte)
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (div_stat.done)
                begin
                    state_next = out_free ? ST_ABSORB : ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    state_next = ST_ABSORB;
                end
            end
            default:
            begin
                state_next = ST_ABSORB;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_ABSORB;
            hash_reg         <= FNV_BASIS;
            pos_reg          <= '0;
            bucket_count_reg <= BUCKET_RESET;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                bucket_count_reg <= bucket_count;
            end
            if (byte_accept)
            begin
                if (last_byte)
                begin
                    hash_reg <= FNV_BASIS;
                    pos_reg  <= '0;
                end
                else
                begin
                    hash_reg <= hash_mixed;
                    pos_reg  <= pos_reg + 1'b1;
                end
            end
            if (load_out)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_accept && last_byte)
        begin
            hash_final_reg <= hash_mixed;
            zero_div_reg   <= (bucket_count_reg == '0);
        end
        if (load_out)
        begin
            bucket_index_reg <= zero_div_reg ? '0 : div_rem;
            full_hash_reg    <= hash_final_reg;
        end
    end

    assign res_valid    = res_valid_reg;
    assign bucket_index = bucket_index_reg;
    assign full_hash    = full_hash_reg;

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// FNV-1a 64-bit identifier bucket unit testbench
// Streams 16-byte identifiers into the unit under randomized burst and gap
// timing while the result side stalls on its own schedule. A byte-level
// hash model predicts every bucket index and full hash, and a scoreboard
// checks each result transaction against the oldest prediction. The bucket
// count is rewritten between phases, including in the middle of an
// identifier, and one phase holds the result side off long enough to back
// the unit up into its input.
// ============================================================================
module tb;
    import fnvb_pkg::*;

    localparam int          ID_LEN         = 16;
    localparam int          LIMIT_CYCLES   = 200000;
    localparam int          SETTLE_CYCLES  = 100;
    localparam int          RANDOM_PHASES  = 8;
    localparam int          HOLD_PHASE     = 3;
    localparam int          LONG_HOLD      = 400;
    localparam logic [63:0] HASH_OFFSET    = 64'hCBF2_9CE4_8422_2325;
    localparam logic [63:0] HASH_PRIME     = 64'h0000_0100_0000_01B3;
    localparam logic [31:0] COUNT_AT_RESET = 32'd16;

    typedef enum logic [2:0] {
        FILL_ZERO,
        FILL_ONES,
        FILL_RAMP,
        FILL_ALT,
        FILL_RANDOM
    } fill_t;

    typedef struct {
        bit          cfg_en;
        logic [31:0] cfg_val;
        int          nbytes;
        fill_t       fill;
        bit          pinned;
        logic [31:0] pin_idx;
    } stim_row_t;

    typedef struct packed {
        logic [BUCKET_W-1:0] bucket;
        logic [HASH_W-1:0]   hash;
    } bucket_result_t;

    typedef struct packed {
        logic                pinned;
        logic [BUCKET_W-1:0] idx;
    } index_pin_t;

    logic                clk;
    logic                rst_n;
    logic                id_valid;
    logic                id_stall;
    logic [BYTE_W-1:0]   id_byte;
    logic                res_valid;
    logic                res_stall;
    logic [BUCKET_W-1:0] bucket_index;
    logic [HASH_W-1:0]   full_hash;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [BUCKET_W-1:0] bucket_count;

    logic [7:0]     byte_q[$];
    bucket_result_t result_q[$];
    index_pin_t     pin_q[$];
    stim_row_t      directed_rows[6];

    bit             hold_req;
    int             mismatch_count;
    int             cycle_count;

    // Hash model state.
    logic [63:0]    run_hash;
    int             run_pos;
    logic [31:0]    model_count;
    logic [63:0]    next_hash;
    logic [63:0]    mod_val;
    bucket_result_t predicted;
    bucket_result_t oldest;
    index_pin_t     pin;

    fnv1a64_uuid_bucket_unit #(
        .ID_BYTES (ID_LEN)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .id_valid     (id_valid),
        .id_stall     (id_stall),
        .id_byte      (id_byte),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .bucket_index (bucket_index),
        .full_hash    (full_hash),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .bucket_count (bucket_count)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("*** FAILED ***");
        $finish;
    end

    // Hash model and scoreboard, both sampled at the accepting edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_hash    = HASH_OFFSET;
            run_pos     = 0;
            model_count = COUNT_AT_RESET;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                model_count = bucket_count;
            end
            if (id_valid && !id_stall)
            begin
                next_hash = (run_hash ^ {56'd0, id_byte}) * HASH_PRIME;
                if (run_pos + 1 >= ID_LEN)
                begin
                    predicted.hash = next_hash;
                    if (model_count == 32'd0)
                    begin
                        predicted.bucket = '0;
                    end
                    else
                    begin
                        mod_val          = next_hash % {32'd0, model_count};
                        predicted.bucket = mod_val[31:0];
                    end
                    if (pin_q.size() != 0)
                    begin
                        pin = pin_q.pop_front();
                        if (pin.pinned)
                        begin
                            predicted.bucket = pin.idx;
                        end
                    end
                    result_q.push_back(predicted);
                    run_hash = HASH_OFFSET;
                    run_pos  = 0;
                end
                else
                begin
                    run_hash = next_hash;
                    run_pos++;
                end
            end
            if (res_valid && !res_stall)
            begin
                if (result_q.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected result: expected none, actual bucket %0d hash %h",
                             $time, bucket_index, full_hash);
                end
                else
                begin
                    oldest = result_q.pop_front();
                    if (bucket_index !== oldest.bucket)
                    begin
                        mismatch_count++;
                        $display("%0t: bucket_index mismatch: expected %0d, actual %0d",
                                 $time, oldest.bucket, bucket_index);
                    end
                    if (full_hash !== oldest.hash)
                    begin
                        mismatch_count++;
                        $display("%0t: full_hash mismatch: expected %h, actual %h",
                                 $time, oldest.hash, full_hash);
                    end
                end
            end
        end
    end

    // Byte sender: bursts of random length separated by random gaps. A byte
    // leaves the queue only when its transaction completes.
    initial
    begin : byte_sender
        int burst_left;
        int gap_left;
        burst_left = 0;
        gap_left   = 0;
        id_valid <= 1'b0;
        id_byte  <= '0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (id_valid && !id_stall)
            begin
                void'(byte_q.pop_front());
            end
            if (!id_valid || !id_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    id_valid <= 1'b0;
                end
                else if (byte_q.size() != 0)
                begin
                    if (burst_left == 0)
                    begin
                        burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 24);
                    end
                    id_valid <= 1'b1;
                    id_byte  <= byte_q[0];
                    burst_left--;
                    if (burst_left == 0)
                    begin
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                begin
                    id_valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: its own stall pattern, plus one long hold on request.
    initial
    begin : result_receiver
        int run_left;
        int hold_left;
        bit stalled;
        run_left  = 0;
        hold_left = 0;
        stalled   = 1'b0;
        res_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_stall <= 1'b1;
            end
            else
            begin
                if (run_left == 0)
                begin
                    case ($urandom_range(0, 3))
                        0:
                        begin
                            stalled  = 1'b1;
                            run_left = $urandom_range(1, 8);
                        end
                        1:
                        begin
                            stalled  = 1'b0;
                            run_left = $urandom_range(40, 120);
                        end
                        default:
                        begin
                            stalled  = 1'b0;
                            run_left = $urandom_range(1, 6);
                        end
                    endcase
                end
                run_left--;
                res_stall <= stalled;
            end
        end
    end

    function automatic bit pipeline_busy();
        return (byte_q.size() != 0) || id_valid || (result_q.size() != 0);
    endfunction

    // Returns once every byte is taken and every result has arrived, then the
    // unit has had time to finish any reduction still in progress.
    task automatic wait_drained();
        forever
        begin
            while (pipeline_busy())
            begin
                @(posedge clk);
            end
            repeat (SETTLE_CYCLES) @(posedge clk);
            if (!pipeline_busy())
            begin
                break;
            end
        end
    endtask

    task automatic write_bucket_count(input logic [31:0] count);
        @(posedge clk);
        cfg_valid    <= 1'b1;
        bucket_count <= count;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : sequencer
        int          queued_pos;
        int          n;
        stim_row_t   row;
        logic [7:0]  b;
        logic [31:0] count;

        rst_n          <= 1'b0;
        cfg_valid      <= 1'b0;
        bucket_count   <= '0;
        hold_req       = 1'b0;
        mismatch_count = 0;

        // A pinned index is one that follows from the bucket count alone.
        directed_rows = '{
            '{1'b0, 32'd0,         16, FILL_ZERO,   1'b0, 32'd0},
            '{1'b1, 32'd1,         16, FILL_ONES,   1'b1, 32'd0},
            '{1'b1, 32'd0,         16, FILL_RAMP,   1'b1, 32'd0},
            '{1'b1, 32'hFFFF_FFFF,  7, FILL_RANDOM, 1'b0, 32'd0},
            '{1'b1, 32'd3,          9, FILL_ALT,    1'b0, 32'd0},
            '{1'b1, 32'hFFFF_FFFF, 16, FILL_ONES,   1'b0, 32'd0}
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The fourth and fifth rows split one identifier, so the count
        // changes while that identifier is partly absorbed.
        queued_pos = 0;
        foreach (directed_rows[r])
        begin
            row = directed_rows[r];
            if (row.cfg_en)
            begin
                wait_drained();
                write_bucket_count(row.cfg_val);
            end
            for (int k = 0; k < row.nbytes; k++)
            begin
                case (row.fill)
                    FILL_ZERO: b = 8'h00;
                    FILL_ONES: b = 8'hFF;
                    FILL_RAMP: b = 8'(k);
                    FILL_ALT:  b = k[0] ? 8'hAA : 8'h55;
                    default:   b = 8'($urandom_range(0, 255));
                endcase
                byte_q.push_back(b);
                queued_pos++;
                if (queued_pos == ID_LEN)
                begin
                    queued_pos = 0;
                    pin_q.push_back('{row.pinned, row.pin_idx});
                end
            end
        end

        // Random phases end at arbitrary byte counts, so most count changes
        // land in the middle of an identifier.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            wait_drained();
            case ($urandom_range(0, 7))
                0:       count = 32'd0;
                1:       count = 32'd1;
                2:       count = 32'hFFFF_FFFF;
                3:       count = 32'd1 << $urandom_range(0, 31);
                4:       count = $urandom_range(2, 64);
                default: count = $urandom;
            endcase
            write_bucket_count(count);
            if (p == HOLD_PHASE)
            begin
                hold_req = 1'b1;
            end
            n = $urandom_range(70, 100);
            repeat (n)
            begin
                case ($urandom_range(0, 15))
                    0:       b = 8'h00;
                    1:       b = 8'hFF;
                    default: b = 8'($urandom_range(0, 255));
                endcase
                byte_q.push_back(b);
            end
        end

        wait_drained();
        if (result_q.size() != 0)
        begin
            mismatch_count++;
        end
        if (mismatch_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
